>>> sv/dfm_pkg.sv
// ----------------------------------------------------------------------------
// dfm_pkg
// Shared types and constants of the debounced fault monitor: counter and
// sample widths, register indexes, reset values and transaction payloads.
// ----------------------------------------------------------------------------
package dfm_pkg;

    // Widths of counters, samples and packed limits
    localparam int COUNT_BITS  = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int LIM_BITS    = 8;
    localparam int CMP_BITS    = (COUNT_BITS > LIM_BITS) ? COUNT_BITS : LIM_BITS;
    localparam int NCHAN       = 4;

    // Configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = NCHAN * LIM_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CURRENT_LIMIT      = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_OVERVOLTAGE_LIMIT  = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNDERVOLTAGE_LIMIT = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_CONFIRM_COUNTS     = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEAL_COUNTS        = CFG_IDX_BITS'(4);

    // Register reset values
    localparam int CURRENT_LIMIT_RST      = 65535;
    localparam int OVERVOLTAGE_LIMIT_RST  = 65535;
    localparam int UNDERVOLTAGE_LIMIT_RST = 0;

    // Channel order inside the packed limit registers
    localparam int CH_OC = 0;
    localparam int CH_OV = 1;
    localparam int CH_UV = 2;
    localparam int CH_OT = 3;

    // Input transaction
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] current_sample;
        logic [SAMPLE_BITS-1:0] voltage_sample;
        logic                   contactor_pin_low;
        logic                   temp_pin_low;
        logic                   reversal_pin_low;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic over_current;
        logic over_voltage;
        logic under_voltage;
        logic over_temperature;
        logic battery_reversed;
    } t_out_item;

    // Per-tick command to one debounce channel
    typedef struct packed {
        logic step;     // a sample is processed this cycle
        logic enable;   // channel is checked; low forces the flag off
        logic faulty;   // the sample is a fault sample
    } t_deb_cmd;

endpackage

>>> sv/dfm_if.sv
// ----------------------------------------------------------------------------
// dfm_if
// Valid/ready channels of the debounced fault monitor: sample input and
// fault flag result.
// ----------------------------------------------------------------------------
interface dfm_in_if
    import dfm_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dfm_out_if
    import dfm_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/dfm_debounce.sv
// ----------------------------------------------------------------------------
// dfm_debounce
// One debounce channel: saturating fault and heal counters with confirm and
// heal limits, and the registered fault flag.
// ----------------------------------------------------------------------------
module dfm_debounce
    import dfm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_deb_cmd            i_cmd,
    input  logic [LIM_BITS-1:0] i_confirm,
    input  logic [LIM_BITS-1:0] i_heal,
    output logic                o_flag
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [COUNT_BITS-1:0] r_fault, n_fault;
    logic [COUNT_BITS-1:0] r_heal, n_heal;
    logic                  r_flag, n_flag;
    logic [COUNT_BITS-1:0] fault_inc;
    logic [COUNT_BITS-1:0] heal_inc;

    // Saturating increments
    assign fault_inc = (r_fault == CNT_MAX) ? r_fault : r_fault + COUNT_BITS'(1);
    assign heal_inc  = (r_heal == CNT_MAX) ? r_heal : r_heal + COUNT_BITS'(1);

    // Advance counters and flag for one sample
    always_comb begin
        n_fault = r_fault;
        n_heal  = r_heal;
        n_flag  = r_flag;
        if (i_cmd.step) begin
            if (!i_cmd.enable) begin
                n_flag = 1'b0;
            end else if (i_cmd.faulty) begin
                n_fault = fault_inc;
                if (CMP_BITS'(fault_inc) >= CMP_BITS'(i_confirm)) begin
                    n_fault = COUNT_BITS'(i_confirm);
                    n_heal  = '0;
                    n_flag  = 1'b1;
                end
            end else begin
                n_heal = heal_inc;
                if (CMP_BITS'(heal_inc) > CMP_BITS'(i_heal)) begin
                    n_fault = '0;
                    n_heal  = COUNT_BITS'(i_heal);
                    n_flag  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault <= '0;
            r_heal  <= '0;
            r_flag  <= 1'b0;
        end else begin
            r_fault <= n_fault;
            r_heal  <= n_heal;
            r_flag  <= n_flag;
        end
    end

    assign o_flag = r_flag;

endmodule

>>> sv/debounced_fault_monitor.sv
// ----------------------------------------------------------------------------
// debounced_fault_monitor
// Debounced overcurrent, overvoltage, undervoltage and over-temperature flags
// with battery reversal pass-through.
// ----------------------------------------------------------------------------
// One sample transaction enters per clock cycle while the result output is
// not stalled. A sample is held in the input register, and its result in
// the flag register. Each channel updates its counters for every processed
// sample. The four flags are the debounce state itself, so a result shows
// the flags after its own sample. While contactor_pin_low is 0 the three
// electrical flags read 0 and their counters hold. Write the configuration
// registers only while no transaction is in flight.
// ----------------------------------------------------------------------------
module debounced_fault_monitor
    import dfm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    dfm_in_if.sink                   i_in,
    dfm_out_if.source                o_out,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // Configuration registers
    logic [SAMPLE_BITS-1:0]   r_cur_lim;
    logic [SAMPLE_BITS-1:0]   r_ov_lim;
    logic [SAMPLE_BITS-1:0]   r_uv_lim;
    logic [CFG_DATA_BITS-1:0] r_confirm;
    logic [CFG_DATA_BITS-1:0] r_heal;

    // Pipeline registers
    logic     r_in_valid, n_in_valid;
    t_in_item r_in;
    logic     r_out_valid, n_out_valid;
    logic     r_rev;

    logic             out_free;
    logic             advance;
    logic             in_take;
    logic [NCHAN-1:0] flags;
    logic [NCHAN-1:0] faulty;
    t_deb_cmd         cmd [NCHAN];

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_lim <= SAMPLE_BITS'(CURRENT_LIMIT_RST);
            r_ov_lim  <= SAMPLE_BITS'(OVERVOLTAGE_LIMIT_RST);
            r_uv_lim  <= SAMPLE_BITS'(UNDERVOLTAGE_LIMIT_RST);
            r_confirm <= '0;
            r_heal    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CURRENT_LIMIT:      r_cur_lim <= SAMPLE_BITS'(i_cfg_data);
                CFG_OVERVOLTAGE_LIMIT:  r_ov_lim  <= SAMPLE_BITS'(i_cfg_data);
                CFG_UNDERVOLTAGE_LIMIT: r_uv_lim  <= SAMPLE_BITS'(i_cfg_data);
                CFG_CONFIRM_COUNTS:     r_confirm <= i_cfg_data;
                CFG_HEAL_COUNTS:        r_heal    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Handshake: the flag stage frees when empty or drained
    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;
    assign in_take    = i_in.valid && i_in.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold input sample and reversal pin
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in.data;
        end
        if (advance) begin
            r_rev <= r_in.reversal_pin_low;
        end
    end

    // Classify the held sample
    assign faulty[CH_OC] = r_in.current_sample > r_cur_lim;
    assign faulty[CH_OV] = r_in.voltage_sample > r_ov_lim;
    assign faulty[CH_UV] = r_in.voltage_sample < r_uv_lim;
    assign faulty[CH_OT] = r_in.temp_pin_low;

    // Debounce channels; temperature runs regardless of the contactor
    for (genvar ch = 0; ch < NCHAN; ch++) begin : g_chan
        assign cmd[ch].step   = advance;
        assign cmd[ch].enable = (ch == CH_OT) ? 1'b1 : r_in.contactor_pin_low;
        assign cmd[ch].faulty = faulty[ch];

        dfm_debounce u_debounce (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (cmd[ch]),
            .i_confirm (r_confirm[ch*LIM_BITS +: LIM_BITS]),
            .i_heal    (r_heal[ch*LIM_BITS +: LIM_BITS]),
            .o_flag    (flags[ch])
        );
    end

    // Drive result transaction
    assign o_out.valid                 = r_out_valid;
    assign o_out.data.over_current     = flags[CH_OC];
    assign o_out.data.over_voltage     = flags[CH_OV];
    assign o_out.data.under_voltage    = flags[CH_UV];
    assign o_out.data.over_temperature = flags[CH_OT];
    assign o_out.data.battery_reversed = r_rev;

`ifndef SYNTHESIS
    // Contactor off clears the electrical flags of that result
    a_contactor_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_in.contactor_pin_low |=> flags[CH_UV:CH_OC] == '0)
        else $error("electrical flag set with contactor disabled");

    // Flags change only when a sample is processed
    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(flags))
        else $error("fault flags changed without a sample");

    // Reversal result follows the processed sample
    a_reversal_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_rev == $past(r_in.reversal_pin_low))
        else $error("battery reversal flag does not match sample");

    // A processed sample always yields a pending result
    a_result_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed sample produced no result");
`endif

endmodule
